FILE: rtl/core/e2q_pkg.sv
// shared types, constants and the cordic arctangent table
`timescale 1ns / 1ps
package e2q_pkg;

   localparam int ANGLE_W = 16;
   localparam int Q14_W = 16;
   localparam int TABLE_LEN = 24;
   localparam int CORDIC_ITERATIONS_DEF = 16;
   localparam int Z_W = 34;
   localparam int XY_W = 33;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic signed [Z_W-1:0] DEG90 = 34'sd1509949440;
   localparam logic signed [Z_W-1:0] DEG180 = 34'sd3019898880;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic signed [17:0] Q14_POS = 18'sd16384;
   localparam logic signed [17:0] Q14_NEG = -18'sd16384;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle_x;
      logic signed [ANGLE_W-1:0] angle_y;
      logic signed [ANGLE_W-1:0] angle_z;
   } req_type;

   typedef struct packed {
      logic signed [Q14_W-1:0] quat_w;
      logic signed [Q14_W-1:0] quat_x;
      logic signed [Q14_W-1:0] quat_y;
      logic signed [Q14_W-1:0] quat_z;
   } rsp_type;

   // reduced half angle (degrees * 2^24) and fold flag for one axis
   typedef struct packed {
      logic signed [Z_W-1:0] z;
      logic                  neg;
   } axis_type;

   typedef struct packed {
      axis_type ax;
      axis_type ay;
      axis_type az;
   } work_type;

   typedef struct packed {
      logic signed [Q14_W-1:0] c;
      logic signed [Q14_W-1:0] s;
   } sc_type;

   function automatic logic signed [Z_W-1:0] atan_deg(input int i);
      logic signed [Z_W-1:0] t;
      case (i)
         0: t = 34'sd754974720;
         1: t = 34'sd445687602;
         2: t = 34'sd235489089;
         3: t = 34'sd119537938;
         4: t = 34'sd60000934;
         5: t = 34'sd30029717;
         6: t = 34'sd15018523;
         7: t = 34'sd7509720;
         8: t = 34'sd3754917;
         9: t = 34'sd1877466;
         10: t = 34'sd938734;
         11: t = 34'sd469367;
         12: t = 34'sd234684;
         13: t = 34'sd117342;
         14: t = 34'sd58671;
         15: t = 34'sd29335;
         16: t = 34'sd14668;
         17: t = 34'sd7334;
         18: t = 34'sd3667;
         19: t = 34'sd1833;
         20: t = 34'sd917;
         21: t = 34'sd458;
         22: t = 34'sd229;
         23: t = 34'sd115;
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic signed [Q14_W-1:0] clamp18(input logic signed [17:0] v);
      logic signed [17:0] r;
      if (v > Q14_POS) r = Q14_POS;
      else if (v < Q14_NEG) r = Q14_NEG;
      else r = v;
      return r[Q14_W-1:0];
   endfunction

endpackage

FILE: rtl/core/e2q_front.sv
// front end: takes angle beats, halves and folds each angle into +-90 degrees
`timescale 1ns / 1ps
module e2q_front
   import e2q_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   output logic     out_valid,
   input  logic     out_stall,
   output work_type out_data
);

   function automatic axis_type fold(input logic signed [ANGLE_W-1:0] a);
      axis_type r;
      logic signed [Z_W-1:0] z;
      z = {a[ANGLE_W-1], a, 17'd0};
      r.neg = 1'b0;
      if (z > DEG90) begin
         z = z - DEG180;
         r.neg = 1'b1;
      end else if (z < -DEG90) begin
         z = z + DEG180;
         r.neg = 1'b1;
      end
      r.z = z;
      return r;
   endfunction

   logic     valid_ff, valid_in;
   work_type data_ff, data_in;

   assign req_stall = valid_ff && out_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (!req_stall) begin
         valid_in = req_valid;
         data_in.ax = fold(req_data.angle_x);
         data_in.ay = fold(req_data.angle_y);
         data_in.az = fold(req_data.angle_z);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/core/e2q_queue.sv
// short fifo between front and back ends
`timescale 1ns / 1ps
module e2q_queue
   import e2q_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_stall,
   input  work_type in_data,
   output logic     out_valid,
   input  logic     out_stall,
   output work_type out_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   work_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   cnt_ff;
   logic push, pop;

   assign in_stall  = (cnt_ff == (AW+1)'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rd_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
         if (pop) rd_ff <= (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
      if (push) mem_ff[wr_ff] <= in_data;
   end

endmodule

FILE: rtl/core/e2q_back.sv
// back end: pipelined cordic per axis, quaternion product, round and saturate
`timescale 1ns / 1ps
module e2q_back
   import e2q_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_stall,
   input  work_type in_data,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam int N = CORDIC_ITERATIONS;
   // stages: 1 load, N cordic, 1 round, 1 product zx, 1 product r, 1 output
   localparam int S = N + 5;

   logic adv;
   logic [S-1:0] v_ff;

   // output register stalls; whole pipe moves when output slot free
   assign adv = !(v_ff[S-1] && rsp_stall);
   assign in_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[S-2:0], in_valid};
   end

   // cordic stage arrays: three axes
   logic signed [XY_W-1:0] cx_ff [3][N+1];
   logic signed [XY_W-1:0] cy_ff [3][N+1];
   logic signed [Z_W-1:0]  cz_ff [3][N+1];
   logic                   cn_ff [3][N+1];
   axis_type ain [3];

   assign ain[0] = in_data.ax;
   assign ain[1] = in_data.ay;
   assign ain[2] = in_data.az;

   genvar a, i;
   generate
      for (a = 0; a < 3; a++) begin : g_axis
         always_ff @(posedge clock) begin
            if (adv) begin
               cx_ff[a][0] <= CORDIC_GAIN;
               cy_ff[a][0] <= '0;
               cz_ff[a][0] <= ain[a].z;
               cn_ff[a][0] <= ain[a].neg;
            end
         end
         for (i = 0; i < N; i++) begin : g_iter
            logic signed [XY_W-1:0] dx, dy;
            assign dx = cy_ff[a][i] >>> i;
            assign dy = cx_ff[a][i] >>> i;
            always_ff @(posedge clock) begin
               if (adv) begin
                  cn_ff[a][i+1] <= cn_ff[a][i];
                  if (!cz_ff[a][i][Z_W-1]) begin
                     cx_ff[a][i+1] <= cx_ff[a][i] - dx;
                     cy_ff[a][i+1] <= cy_ff[a][i] + dy;
                     cz_ff[a][i+1] <= cz_ff[a][i] - atan_deg(i);
                  end else begin
                     cx_ff[a][i+1] <= cx_ff[a][i] + dx;
                     cy_ff[a][i+1] <= cy_ff[a][i] - dy;
                     cz_ff[a][i+1] <= cz_ff[a][i] + atan_deg(i);
                  end
               end
            end
         end
      end
   endgenerate

   // round cordic outputs to q14 (chain of stage N -> registered sc)
   sc_type sc_ff [3];
   generate
      for (a = 0; a < 3; a++) begin : g_rnd
         logic signed [XY_W-1:0] xr, yr;
         logic signed [17:0] xq, yq;
         assign xr = (cx_ff[a][N] + XY_W'(32768)) >>> 16;
         assign yr = (cy_ff[a][N] + XY_W'(32768)) >>> 16;
         assign xq = cn_ff[a][N] ? -xr[17:0] : xr[17:0];
         assign yq = cn_ff[a][N] ? -yr[17:0] : yr[17:0];
         always_ff @(posedge clock) begin
            if (adv) begin
               sc_ff[a].c <= clamp18(xq);
               sc_ff[a].s <= clamp18(yq);
            end
         end
      end
   endgenerate

   // z*x product: (cz,0,0,sz)*(cx,sx,0,0) = (cz cx, cz sx, sz sx, sz cx), q28
   logic signed [31:0] zx_ff [4];
   logic signed [Q14_W-1:0] cy_d_ff, sy_d_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         zx_ff[0] <= 32'(sc_ff[2].c * sc_ff[0].c);
         zx_ff[1] <= 32'(sc_ff[2].c * sc_ff[0].s);
         zx_ff[2] <= 32'(sc_ff[2].s * sc_ff[0].s);
         zx_ff[3] <= 32'(sc_ff[2].s * sc_ff[0].c);
         cy_d_ff <= sc_ff[1].c;
         sy_d_ff <= sc_ff[1].s;
      end
   end

   // (zx)*(cy,0,sy,0): w=a0cy-a2sy x=a1cy-a3sy y=a0sy+a2cy z=a3cy+a1sy
   logic signed [47:0] p [8];
   assign p[0] = 48'(zx_ff[0] * cy_d_ff);
   assign p[1] = 48'(zx_ff[2] * sy_d_ff);
   assign p[2] = 48'(zx_ff[1] * cy_d_ff);
   assign p[3] = 48'(zx_ff[3] * sy_d_ff);
   assign p[4] = 48'(zx_ff[0] * sy_d_ff);
   assign p[5] = 48'(zx_ff[2] * cy_d_ff);
   assign p[6] = 48'(zx_ff[3] * cy_d_ff);
   assign p[7] = 48'(zx_ff[1] * sy_d_ff);

   logic signed [47:0] pr_ff [8];
   always_ff @(posedge clock) begin
      if (adv) for (int k = 0; k < 8; k++) pr_ff[k] <= p[k];
   end

   logic signed [48:0] r [4];
   assign r[0] = 49'(pr_ff[0]) - 49'(pr_ff[1]);
   assign r[1] = 49'(pr_ff[2]) - 49'(pr_ff[3]);
   assign r[2] = 49'(pr_ff[4]) + 49'(pr_ff[5]);
   assign r[3] = 49'(pr_ff[6]) + 49'(pr_ff[7]);

   function automatic logic signed [Q14_W-1:0] rnd(input logic signed [48:0] v);
      logic signed [48:0] t;
      logic signed [20:0] q;
      t = (v + 49'sd134217728) >>> 28;
      q = t[20:0];
      if (q > 21'sd16384) q = 21'sd16384;
      else if (q < -21'sd16384) q = -21'sd16384;
      return q[Q14_W-1:0];
   endfunction

   rsp_type out_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff.quat_w <= rnd(r[0]);
         out_ff.quat_x <= rnd(r[1]);
         out_ff.quat_y <= rnd(r[2]);
         out_ff.quat_z <= rnd(r[3]);
      end
   end

   assign rsp_valid = v_ff[S-1];
   assign rsp_data  = out_ff;

endmodule

FILE: rtl/core/euler_to_quaternion_top.sv
// top level: euler angles (z, x, y order) to unit quaternion
//
//  channel | direction | handshake        | beat
//  req     | in        | req_valid/stall  | req_type: angle_x, angle_y, angle_z
//  rsp     | out       | rsp_valid/stall  | rsp_type: quat_w, quat_x, quat_y, quat_z
//
// one beat per cycle accepted and returned at full rate while rsp is not stalled
// after the accepting edge a beat passes, in order, through the queue write,
// cordic load, one cordic stage per iteration, round, two product stages, output register
// reset is synchronous and clears only valid and queue pointers
// a rsp stall freezes the back pipe; the queue absorbs front beats until full
`timescale 1ns / 1ps
module euler_to_quaternion_top
   import e2q_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // front to queue
   logic     f_valid, f_stall;
   work_type f_data;
   // queue to back
   logic     q_valid, q_stall;
   work_type q_data;

   e2q_front u_front (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .out_valid(f_valid), .out_stall(f_stall), .out_data(f_data)
   );

   e2q_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
      .out_valid(q_valid), .out_stall(q_stall), .out_data(q_data)
   );

   e2q_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_stall(q_stall), .in_data(q_data),
      .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule

FILE: rtl/core/e2q_checker.sv
// port-level checks on the top level
`timescale 1ns / 1ps
module e2q_checker
   import e2q_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed under stall");

   a_w_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.quat_w <= 16'sd16384 && rsp_data.quat_w >= -16'sd16384))
      else $error("quat_w out of range");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_open_when_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req stalled while rsp empty");

endmodule

bind euler_to_quaternion_top e2q_checker u_e2q_checker (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall, .rsp_data
);
